/* hdl/gbar_pkg.sv */
// Shared constants and widths for the grid bin average resampler.
package gbar_pkg;

    localparam int X_W          = 16;
    localparam int Y_W          = 32;
    localparam int SUM_W        = 48;
    localparam int NCFG_W       = 11;
    localparam int MAX_BINS     = 1024;
    localparam int BIN_W        = $clog2(MAX_BINS);
    localparam int NBIN_W       = $clog2(MAX_BINS + 1);
    localparam int MAX_PER_BIN_DEF = 65535;
    localparam int QUEUE_DEPTH  = 4;
    localparam int DIV_BITS     = 2;
    localparam int DIV_STEPS    = SUM_W / DIV_BITS;
    localparam int STEP_W       = $clog2(DIV_STEPS);
    localparam int BIN_COUNT_RST = 256;

    localparam logic [1:0] ST_AVG   = 2'd0;
    localparam logic [1:0] ST_ERR   = 2'd1;
    localparam logic [1:0] ST_READY = 2'd2;

    localparam logic REG_BIN_COUNT = 1'b0;

endpackage

/* hdl/gbar_queue.sv */
// Small FIFO that carries result jobs from the front end to the back end.
module gbar_queue import gbar_pkg::*; #(
    parameter int W     = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill count exceeds its depth");

endmodule

/* hdl/gbar_front.sv */
// Front end: bins each sample, keeps the running sum and count, and queues result jobs.
module gbar_front import gbar_pkg::*; #(
    parameter int MAX_PER_BIN = MAX_PER_BIN_DEF,
    parameter int CNT_W       = $clog2(MAX_PER_BIN + 1),
    parameter int JOB_W       = 2 + BIN_W + SUM_W + CNT_W + 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [NCFG_W-1:0] bin_count,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [X_W-1:0]    s_sample_x,
    input  logic [Y_W-1:0]    s_sample_y,
    input  logic              s_set_last,
    output logic              job_valid,
    input  logic              job_ready,
    output logic [JOB_W-1:0]  job_data
);

    typedef struct packed {
        logic [1:0]       status;
        logic [BIN_W-1:0] idx;
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] cnt;
        logic             last;
    } job_t;

    logic [BIN_W-1:0] cur_reg, cur_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             err_reg, err_next;
    job_t             pend_reg [3];
    job_t             pend_next [3];
    logic [1:0]       left_reg, left_next;
    logic [1:0]       pos_reg, pos_next;

    logic [NBIN_W-1:0]      n_eff;
    logic [X_W+NBIN_W-1:0]  prod;
    logic [BIN_W-1:0]       b;
    logic [SUM_W-1:0]       ext;
    logic                   accept;

    assign s_ready   = (left_reg == 2'd0);
    assign accept    = s_valid && s_ready;
    assign job_valid = (left_reg != 2'd0);
    assign job_data  = pend_reg[pos_reg];

    // Out-of-range bin counts are clamped to the supported range.
    always_comb begin
        if (bin_count == '0) begin
            n_eff = NBIN_W'(1);
        end else if (bin_count > NCFG_W'(MAX_BINS)) begin
            n_eff = NBIN_W'(MAX_BINS);
        end else begin
            n_eff = NBIN_W'(bin_count);
        end
        prod = X_W'(s_sample_x) * (X_W + NBIN_W)'(n_eff);
        b    = prod[X_W +: BIN_W];
        ext  = {{(SUM_W - Y_W){s_sample_y[Y_W-1]}}, s_sample_y};
    end

    always_comb begin
        logic [BIN_W-1:0] cur1;
        logic [SUM_W-1:0] sum1;
        logic [CNT_W-1:0] cnt1;
        logic             go_on;
        logic [1:0]       k;
        job_t             e [3];

        cur1  = cur_reg;
        sum1  = sum_reg;
        cnt1  = cnt_reg;
        go_on = 1'b0;
        k     = 2'd0;
        for (int i = 0; i < 3; i++) begin
            e[i] = '0;
        end
        cur_next = cur_reg;
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        err_next = err_reg;

        if (err_reg) begin
            if (s_set_last) begin
                cur_next = '0;
                sum_next = '0;
                cnt_next = '0;
                err_next = 1'b0;
            end
        end else if (b <= cur_reg) begin
            // Samples at or behind the current bin are added to it until its count reaches the limit.
            if (cnt_reg < CNT_W'(MAX_PER_BIN)) begin
                sum1 = sum_reg + ext;
                cnt1 = cnt_reg + CNT_W'(1);
            end
            go_on = 1'b1;
        end else if (cnt_reg == '0) begin
            e[0]     = '{status: ST_ERR, idx: cur_reg, sum: '0, cnt: '0, last: 1'b0};
            k        = 2'd1;
            err_next = !s_set_last;
            sum_next = '0;
            cnt_next = '0;
            if (s_set_last) begin
                cur_next = '0;
            end
        end else begin
            e[0] = '{status: ST_AVG, idx: cur_reg, sum: sum_reg, cnt: cnt_reg, last: 1'b0};
            k    = 2'd1;
            if ({1'b0, b} > ({1'b0, cur_reg} + (BIN_W + 1)'(1))) begin
                // A bin was skipped: report the first empty one.
                e[1]     = '{status: ST_ERR, idx: cur_reg + BIN_W'(1), sum: '0, cnt: '0,
                             last: 1'b0};
                k        = 2'd2;
                err_next = !s_set_last;
                sum_next = '0;
                cnt_next = '0;
                if (s_set_last) begin
                    cur_next = '0;
                end
            end else begin
                cur1  = b;
                sum1  = ext;
                cnt1  = CNT_W'(1);
                go_on = 1'b1;
            end
        end

        if (go_on) begin
            if (s_set_last) begin
                e[k] = '{status: ST_AVG, idx: cur1, sum: sum1, cnt: cnt1, last: 1'b0};
                if (({1'b0, cur1} + NBIN_W'(1)) < n_eff) begin
                    e[k + 2'd1] = '{status: ST_ERR, idx: cur1 + BIN_W'(1), sum: '0, cnt: '0,
                                    last: 1'b0};
                end else begin
                    e[k + 2'd1] = '{status: ST_READY, idx: '0, sum: '0, cnt: '0, last: 1'b0};
                end
                k        = k + 2'd2;
                cur_next = '0;
                sum_next = '0;
                cnt_next = '0;
            end else begin
                cur_next = cur1;
                sum_next = sum1;
                cnt_next = cnt1;
            end
        end

        if (k != 2'd0) begin
            e[k - 2'd1].last = 1'b1;
        end

        for (int i = 0; i < 3; i++) begin
            pend_next[i] = e[i];
        end
        left_next = k;
        pos_next  = 2'd0;
        if (!accept) begin
            cur_next = cur_reg;
            sum_next = sum_reg;
            cnt_next = cnt_reg;
            err_next = err_reg;
            for (int i = 0; i < 3; i++) begin
                pend_next[i] = pend_reg[i];
            end
            left_next = left_reg;
            pos_next  = pos_reg;
            if (job_valid && job_ready) begin
                left_next = left_reg - 2'd1;
                pos_next  = pos_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg  <= '0;
            sum_reg  <= '0;
            cnt_reg  <= '0;
            err_reg  <= 1'b0;
            left_reg <= 2'd0;
            pos_reg  <= 2'd0;
        end else begin
            cur_reg  <= cur_next;
            sum_reg  <= sum_next;
            cnt_reg  <= cnt_next;
            err_reg  <= err_next;
            left_reg <= left_next;
            pos_reg  <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            pend_reg[i] <= pend_next[i];
        end
    end

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_set_last) |=> (cur_reg == '0 && cnt_reg == '0 && !err_reg))
        else $error("set end did not clear the bin state");

endmodule

/* hdl/gbar_back.sv */
// Back end: divides each closed bin's sum by its count and drives the result register.
module gbar_back import gbar_pkg::*; #(
    parameter int CNT_W = 16,
    parameter int JOB_W = 2 + BIN_W + SUM_W + CNT_W + 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             job_valid,
    output logic             job_ready,
    input  logic [JOB_W-1:0] job_data,
    output logic [BIN_W-1:0] m_bin_index,
    output logic [Y_W-1:0]   m_average_y,
    output logic [1:0]       m_status,
    output logic             m_last_result,
    output logic             m_valid,
    input  logic             m_ready
);

    typedef struct packed {
        logic [1:0]       status;
        logic [BIN_W-1:0] idx;
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] cnt;
        logic             last;
    } job_t;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]        state_reg, state_next;
    job_t              job_reg, job_next;
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [BIN_W-1:0]  idx_reg;
    logic [Y_W-1:0]    avg_reg;
    logic [1:0]        status_reg;
    logic              last_reg;
    logic              valid_reg, valid_next;

    job_t              job_in;
    logic              load_out;
    logic [SUM_W-1:0]  mag_in;
    logic [SUM_W-1:0]  quo_step;
    logic [CNT_W-1:0]  rem_step;
    logic [Y_W-1:0]    avg_val;

    assign job_in    = job_t'(job_data);
    assign job_ready = (state_reg == S_IDLE);
    assign load_out  = (state_reg == S_DONE) && (!valid_reg || m_ready);
    assign mag_in    = job_in.sum[SUM_W-1] ? (~job_in.sum + SUM_W'(1)) : job_in.sum;

    // Restoring division of the sum's magnitude, two quotient bits per cycle.
    always_comb begin
        logic [CNT_W:0]   t;
        logic [CNT_W-1:0] r;
        logic [SUM_W-1:0] q;
        r = rem_reg;
        q = quo_reg;
        for (int i = 0; i < DIV_BITS; i++) begin
            t = {r, q[SUM_W-1]};
            if (t >= {1'b0, job_reg.cnt}) begin
                t = t - {1'b0, job_reg.cnt};
                q = {q[SUM_W-2:0], 1'b1};
            end else begin
                q = {q[SUM_W-2:0], 1'b0};
            end
            r = t[CNT_W-1:0];
        end
        quo_step = q;
        rem_step = r;
    end

    // Signed mean from the magnitude quotient, saturated to 32 bits.
    always_comb begin
        if (job_reg.status != ST_AVG || job_reg.cnt == '0) begin
            avg_val = '0;
        end else if (job_reg.sum[SUM_W-1]) begin
            if (quo_reg > SUM_W'(33'h0_8000_0000)) begin
                avg_val = 32'h8000_0000;
            end else begin
                avg_val = ~quo_reg[Y_W-1:0] + Y_W'(1);
            end
        end else if (quo_reg > SUM_W'(32'h7FFF_FFFF)) begin
            avg_val = 32'h7FFF_FFFF;
        end else begin
            avg_val = quo_reg[Y_W-1:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        job_next   = job_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (job_valid) begin
                    job_next = job_in;
                    if (job_in.status == ST_AVG && job_in.cnt != '0) begin
                        quo_next   = mag_in;
                        rem_next   = '0;
                        step_next  = '0;
                        state_next = S_DIV;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DIV: begin
                quo_next  = quo_step;
                rem_next  = rem_step;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (load_out) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        if (load_out) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg <= job_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (load_out) begin
            idx_reg    <= job_reg.idx;
            avg_reg    <= avg_val;
            status_reg <= job_reg.status;
            last_reg   <= job_reg.last;
        end
    end

    assign m_bin_index   = idx_reg;
    assign m_average_y   = avg_reg;
    assign m_status      = status_reg;
    assign m_last_result = last_reg;
    assign m_valid       = valid_reg;

    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (step_reg < STEP_W'(DIV_STEPS)))
        else $error("divider step counter ran past its last step");

    a_pop_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (job_valid && job_ready) |=> (state_reg != S_IDLE))
        else $error("back end took a job but stayed idle");

    a_err_zero_avg: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_out && job_reg.status != ST_AVG) |-> (avg_val == '0))
        else $error("non-average result carries a nonzero mean");

endmodule

/* hdl/grid_bin_average_resampler.sv */
// Top level of the grid bin average resampler: register port, front end, job queue, back end.
// A bin average passes through the front end's job registers, the queue, the back end's
// divide steps and its output register; an error or map ready result skips the division.
// The shared divider in the back end works on one bin average at a time, and the back end
// takes no new job until its last result is loaded, so a closed bin per sample stalls input.
// Reset is synchronous and active low: bin_count returns to 256, all bin state clears,
// the queue empties and no result is pending.
module grid_bin_average_resampler import gbar_pkg::*; #(
    parameter int MAX_PER_BIN = MAX_PER_BIN_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,

    input  logic              s_valid,
    output logic              s_ready,
    input  logic [X_W-1:0]    s_sample_x,
    input  logic [Y_W-1:0]    s_sample_y,
    input  logic              s_set_last,

    output logic              m_valid,
    input  logic              m_ready,
    output logic [BIN_W-1:0]  m_bin_index,
    output logic [Y_W-1:0]    m_average_y,
    output logic [1:0]        m_status,
    output logic              m_last_result
);

    // The per-bin sample count is only as wide as its limit requires.
    localparam int CNT_W = $clog2(MAX_PER_BIN + 1);
    localparam int JOB_W = 2 + BIN_W + SUM_W + CNT_W + 1;

    logic [NCFG_W-1:0] bin_count_reg;
    logic              cfg_write;

    logic              q_in_valid, q_in_ready;
    logic [JOB_W-1:0]  q_in_data;
    logic              q_out_valid, q_out_ready;
    logic [JOB_W-1:0]  q_out_data;

    // The register port never stalls. Word address bit 2 selects the register;
    // the byte lane bits below it are ignored.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_BIN_COUNT) ? 32'(bin_count_reg) : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_count_reg <= NCFG_W'(BIN_COUNT_RST);
        end else if (cfg_write && paddr[2] == REG_BIN_COUNT) begin
            bin_count_reg <= pwdata[NCFG_W-1:0];
        end
    end

    // The front end classifies each sample and turns it into at most three result
    // jobs, which it hands to the queue one per cycle while the queue has room. It takes the
    // next sample once the jobs of the previous one are all queued.
    gbar_front #(
        .MAX_PER_BIN (MAX_PER_BIN),
        .CNT_W       (CNT_W),
        .JOB_W       (JOB_W)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .bin_count  (bin_count_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_sample_x (s_sample_x),
        .s_sample_y (s_sample_y),
        .s_set_last (s_set_last),
        .job_valid  (q_in_valid),
        .job_ready  (q_in_ready),
        .job_data   (q_in_data)
    );

    // The queue lets the front end run ahead while the divider is busy.
    gbar_queue #(
        .W     (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_in_valid),
        .in_ready  (q_in_ready),
        .in_data   (q_in_data),
        .out_valid (q_out_valid),
        .out_ready (q_out_ready),
        .out_data  (q_out_data)
    );

    // The back end works one job at a time and holds each result in an output
    // register, so a stalled consumer only stops the back end once it is done.
    gbar_back #(
        .CNT_W (CNT_W),
        .JOB_W (JOB_W)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .job_valid     (q_out_valid),
        .job_ready     (q_out_ready),
        .job_data      (q_out_data),
        .m_bin_index   (m_bin_index),
        .m_average_y   (m_average_y),
        .m_status      (m_status),
        .m_last_result (m_last_result),
        .m_valid       (m_valid),
        .m_ready       (m_ready)
    );

endmodule
